>>> src/bbt_pkg.sv
// ----------------------------------------------------------------------------
// Bad block table package
// Shared types, codes and field layout for the bad block table and remapper.
// ----------------------------------------------------------------------------
package bbt_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int BLOCK_SHIFT_DEF = 17;

  localparam int BLOCK_W = 15;
  localparam int CAND_W  = 16;
  localparam int ADDR_W  = 32;
  localparam int TOTAL_W = 16;
  localparam int OP_W    = 2;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  localparam logic [TOTAL_W-1:0] TOTAL_RESET = 16'd2048;
  localparam logic [ADDR_W-1:0]  ADDR_NONE   = 32'hFFFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK = 2'd0,
    OP_MARK  = 2'd1,
    OP_FIND  = 2'd2,
    OP_REMAP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_LOOK,
    S_SCAN,
    S_WRITE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic scan;
    logic append;
  } tbl_req_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic full;
  } tbl_rsp_t;

endpackage

>>> src/bad_block_table_remap_top.sv
// ----------------------------------------------------------------------------
// Bad block table with address remap
// Request channel in, one result item out per request, block limit register.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request item: tuser = op, tdata = block, address,
//   nand_target. m_axis returns exactly one result item per request:
//   tdata = is_bad, status, result_block, result_address.
//   cfg_valid/cfg_ready/cfg_data writes the block limit; write it only while idle.
// Timing:
//   Requests are served one at a time. A lookup walks the list memory one
//   entry a cycle until a hit or the end of the list; a search adds a step
//   state per candidate. A check result follows its lookup; a mark that
//   appends adds a write state. A find or a remap of a listed block takes a
//   lookup per listed block stepped over plus one. A remap that is not NAND
//   or lands outside the block range skips the lookup.
// Reset: rst empties the table, sets the block limit to 2048, drops any result.
// Stall: the result waits in the output register while m_axis_tready is low;
//   the next request is taken meanwhile and its result waits for the slot.
module bad_block_table_remap_top #(
  parameter int TABLE_DEPTH = bbt_pkg::TABLE_DEPTH_DEF,
  parameter int BLOCK_SHIFT = bbt_pkg::BLOCK_SHIFT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [14:0] block, [46:15] address, [47] nand_target
  input  logic [bbt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] op
  input  logic [bbt_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] is_bad, [2:1] status, [17:3] result_block, [49:18] result_address
  output logic [bbt_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bbt_pkg::TOTAL_W-1:0]       cfg_data
);
  import bbt_pkg::*;

  state_t              state, state_next;
  op_t                 op_r, op_next;
  logic [CAND_W-1:0]   cand, cand_next;
  logic [CAND_W-1:0]   start, start_next;
  logic                up, up_next;
  logic                searching, searching_next;
  logic                is_bad, is_bad_next;
  status_t             status, status_next;
  logic [BLOCK_W-1:0]  rblock, rblock_next;
  logic [ADDR_W-1:0]   raddr, raddr_next;
  logic [TOTAL_W-1:0]  block_limit;

  logic                out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                out_load;

  op_t                 in_op;
  logic [BLOCK_W-1:0]  in_block;
  logic [ADDR_W-1:0]   in_addr;
  logic                in_nand;
  logic [ADDR_W-1:0]   cur_block;
  logic                cur_fits;
  logic [CAND_W-1:0]   cand_inc;
  logic [ADDR_W-1:0]   found_addr;

  tbl_req_t            req;
  tbl_rsp_t            rsp;

  assign in_op     = op_t'(s_axis_tuser);
  assign in_block  = s_axis_tdata[BLOCK_W-1:0];
  assign in_addr   = s_axis_tdata[BLOCK_W +: ADDR_W];
  assign in_nand   = s_axis_tdata[BLOCK_W + ADDR_W];
  assign cur_block = in_addr >> BLOCK_SHIFT;
  assign cur_fits  = ((cur_block >> BLOCK_W) == '0);
  assign cand_inc  = CAND_W'(cand + 1'b1);
  assign found_addr = ADDR_W'(ADDR_W'(cand) << BLOCK_SHIFT);

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  assign req.scan   = (state == S_LOOK);
  assign req.append = (state == S_WRITE);

  bbt_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk (clk),
    .rst (rst),
    .req (req),
    .key (cand),
    .rsp (rsp)
  );

  always_comb begin
    state_next     = state;
    op_next        = op_r;
    cand_next      = cand;
    start_next     = start;
    up_next        = up;
    searching_next = searching;
    is_bad_next    = is_bad;
    status_next    = status;
    rblock_next    = rblock;
    raddr_next     = raddr;
    out_load       = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_next        = in_op;
          is_bad_next    = 1'b0;
          status_next    = ST_OK;
          rblock_next    = '0;
          raddr_next     = '0;
          searching_next = 1'b0;
          up_next        = 1'b1;
          cand_next      = CAND_W'(in_block);
          start_next     = CAND_W'(in_block);
          unique case (in_op)
            OP_CHECK, OP_MARK: begin
              state_next = S_LOOK;
            end
            OP_FIND: begin
              searching_next = 1'b1;
              state_next     = S_PREP;
            end
            OP_REMAP: begin
              raddr_next = in_addr;
              if (in_nand && cur_fits) begin
                cand_next  = cur_block[CAND_W-1:0];
                state_next = S_LOOK;
              end else begin
                state_next = S_DONE;
              end
            end
            default: begin
              state_next = S_DONE;
            end
          endcase
        end
      end
      S_PREP: begin
        if (up) begin
          if (cand < block_limit) begin
            state_next = S_LOOK;
          end else begin
            up_next   = 1'b0;
            cand_next = '0;
          end
        end else if (cand < start) begin
          state_next = S_LOOK;
        end else begin
          status_next = ST_NONE;
          rblock_next = '0;
          if (op_r == OP_REMAP) begin
            raddr_next = ADDR_NONE;
          end
          state_next = S_DONE;
        end
      end
      S_LOOK: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (rsp.done) begin
          if (searching) begin
            if (rsp.hit) begin
              cand_next  = cand_inc;
              state_next = S_PREP;
            end else begin
              if (op_r == OP_FIND) begin
                rblock_next = cand[BLOCK_W-1:0];
              end else begin
                raddr_next = found_addr;
              end
              state_next = S_DONE;
            end
          end else begin
            state_next = S_DONE;
            case (op_r)
              OP_CHECK: begin
                is_bad_next = rsp.hit;
              end
              OP_MARK: begin
                if (rsp.hit) begin
                  is_bad_next = 1'b1;
                end else if (rsp.full) begin
                  status_next = ST_FULL;
                end else begin
                  is_bad_next = 1'b1;
                  state_next  = S_WRITE;
                end
              end
              default: begin
                if (rsp.hit) begin
                  is_bad_next    = 1'b1;
                  searching_next = 1'b1;
                  up_next        = 1'b1;
                  cand_next      = cand_inc;
                  start_next     = cand_inc;
                  state_next     = S_PREP;
                end
              end
            endcase
          end
        end
      end
      S_WRITE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_next;
    cand      <= cand_next;
    start     <= start_next;
    up        <= up_next;
    searching <= searching_next;
    is_bad    <= is_bad_next;
    status    <= status_next;
    rblock    <= rblock_next;
    raddr     <= raddr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_limit <= TOTAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      block_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {(OUT_DATA_W - ADDR_W - BLOCK_W - 3)'(0), raddr, rblock, status, is_bad};
    end
  end

`ifndef NO_ASSERTIONS
  a_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> state == S_SCAN)
    else $error("table answered outside a lookup");

  a_no_append_full: assert property (@(posedge clk) disable iff (rst)
    req.append |-> !rsp.full)
    else $error("append into a full table");

  a_prep_searching: assert property (@(posedge clk) disable iff (rst)
    state == S_PREP |-> searching)
    else $error("search step without an active search");

  a_key_stable: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !rsp.done) |=> $stable(cand))
    else $error("lookup key changed during a scan");
`endif

endmodule

>>> src/bbt_table.sv
// ----------------------------------------------------------------------------
// Bad block table storage
// Single-port list memory with a fill count and a linear lookup engine.
// ----------------------------------------------------------------------------
module bbt_table #(
  parameter int DEPTH = bbt_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bbt_pkg::tbl_req_t            req,
  input  logic [bbt_pkg::CAND_W-1:0]   key,
  output bbt_pkg::tbl_rsp_t            rsp
);
  import bbt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [BLOCK_W-1:0] mem [DEPTH];
  logic [BLOCK_W-1:0] rdata;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_idx;
  logic               busy;
  logic               pend;
  logic               last_d;
  logic               issue;
  logic               last;
  logic               hit;
  logic               miss;

  assign issue = busy && (rd_idx < count);
  assign last  = (rd_idx == CW'(count - 1'b1));
  assign hit   = busy && pend && (CAND_W'(rdata) == key);
  assign miss  = busy && !hit && ((pend && last_d) || (!pend && (rd_idx == count)));

  assign rsp.done = hit || miss;
  assign rsp.hit  = hit;
  assign rsp.full = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      pend   <= 1'b0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (req.scan) begin
        busy   <= 1'b1;
        pend   <= 1'b0;
        rd_idx <= '0;
      end else if (busy) begin
        if (rsp.done) begin
          busy <= 1'b0;
        end
        pend <= issue;
        if (issue) begin
          rd_idx <= CW'(rd_idx + 1'b1);
        end
      end
      if (req.append) begin
        count <= CW'(count + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    last_d <= last;
    if (req.append) begin
      mem[count[AW-1:0]] <= key[BLOCK_W-1:0];
    end
    if (issue) begin
      rdata <= mem[rd_idx[AW-1:0]];
    end
  end

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad block table remap testbench
// Sends check, mark, find and remap requests over the request stream. A local
// copy of the bad block list and the block limit predicts each result item, and
// every returned item is compared field by field against the oldest
// prediction. The block limit is rewritten between phases while the block idles.
// ----------------------------------------------------------------------------
module tb;
  import bbt_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int BLOCK_SHIFT = BLOCK_SHIFT_DEF;
  localparam int N_PHASES = 6;
  localparam int PHASE_ITEMS = 250;
  localparam longint unsigned MAX_ITEM_CYC = (TABLE_DEPTH + 1) * (TABLE_DEPTH + 5) + 64;
  localparam longint unsigned CYCLE_LIMIT = 3 * (N_PHASES * PHASE_ITEMS + 100) * MAX_ITEM_CYC;

  typedef struct packed {
    op_t               op;
    logic              nand_tgt;
    logic [ADDR_W-1:0] addr;
    logic [BLOCK_W-1:0] blk;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  raddr;
    logic [BLOCK_W-1:0] rblk;
    status_t            st;
    logic               bad;
  } res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [TOTAL_W-1:0]    cfg_data = '0;

  req_t               pending_reqs[$];
  res_t               exp_results[$];
  logic [BLOCK_W-1:0] bad_tab[$];
  logic [TOTAL_W-1:0] total_blk = TOTAL_RESET;
  req_t               cur_req;
  int unsigned        acc_count = 0;
  int unsigned        drv_seen = 0;
  int unsigned        send_idle_pct = 8;
  int unsigned        recv_idle_pct = 52;
  int unsigned        err_count = 0;
  longint unsigned    cyc_count = 0;

  bad_block_table_remap_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit is_listed(input int unsigned b);
    foreach (bad_tab[i]) begin
      if (bad_tab[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  // upward from start below total_blk, then wrap from 0 up to start
  function automatic bit find_good(input int unsigned start, output int unsigned found);
    found = 0;
    for (int unsigned b = start; b < total_blk; b++) begin
      if (!is_listed(b)) begin
        found = b;
        return 1'b1;
      end
    end
    for (int unsigned b = 0; b < start; b++) begin
      if (!is_listed(b)) begin
        found = b;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_bbt(input req_t r);
    res_t        res;
    int unsigned cur;
    int unsigned found;
    res = '0;
    case (r.op)
      OP_CHECK: begin
        res.bad = is_listed(32'(r.blk));
      end
      OP_MARK: begin
        if (is_listed(32'(r.blk))) begin
          res.bad = 1'b1;
        end else if (bad_tab.size() >= TABLE_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          bad_tab.push_back(r.blk);
          res.bad = 1'b1;
        end
      end
      OP_FIND: begin
        if (find_good(32'(r.blk), found)) res.rblk = BLOCK_W'(found);
        else res.st = ST_NONE;
      end
      default: begin
        res.raddr = r.addr;
        cur = r.addr >> BLOCK_SHIFT;
        if (r.nand_tgt && is_listed(cur)) begin
          res.bad = 1'b1;
          if (find_good(cur + 1, found)) begin
            res.raddr = ADDR_W'(found << BLOCK_SHIFT);
          end else begin
            res.st = ST_NONE;
            res.raddr = ADDR_NONE;
          end
        end
      end
    endcase
    return res;
  endfunction

  // cluster blocks near 0, near 2048, at the top and around the block limit, or pick any block
  function automatic logic [BLOCK_W-1:0] pick_block();
    int unsigned lo;
    int unsigned hi;
    lo = (total_blk > 64) ? total_blk - 64 : 0;
    hi = (total_blk + 8 > 32767) ? 32767 : total_blk + 8;
    case ($urandom_range(4))
      0: return BLOCK_W'($urandom_range(47, 0));
      1: return BLOCK_W'($urandom_range(2063, 2000));
      2: return BLOCK_W'($urandom_range(32767, 32700));
      3: return BLOCK_W'($urandom_range(hi, lo));
      default: return BLOCK_W'($urandom());
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t        r;
    int unsigned roll;
    roll = $urandom_range(99);
    r.op = (roll < 25) ? OP_CHECK : (roll < 45) ? OP_MARK : (roll < 70) ? OP_FIND : OP_REMAP;
    r.blk = pick_block();
    r.nand_tgt = ($urandom_range(99) < 80);
    if (r.op == OP_REMAP) begin
      r.addr = (ADDR_W'(pick_block()) << BLOCK_SHIFT)
             | ($urandom() & ((32'd1 << BLOCK_SHIFT) - 1));
    end else begin
      r.addr = $urandom();
    end
    return r;
  endfunction

  task automatic push_req(input op_t op, input int unsigned blk, input logic [31:0] addr,
                          input bit nand_tgt);
    req_t r;
    r.op = op;
    r.blk = BLOCK_W'(blk);
    r.addr = addr;
    r.nand_tgt = nand_tgt;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drain();
    while (pending_reqs.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_total(input logic [TOTAL_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    total_blk = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : check_and_predict
    res_t got;
    res_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = res_t'(m_axis_tdata[$bits(res_t)-1:0]);
      if (exp_results.size() == 0) begin
        $display("%0t: unexpected result item, expected none, actual %h", $time, got);
        err_count++;
      end else begin
        want = exp_results.pop_front();
        check_field("is_bad", 32'(want.bad), 32'(got.bad));
        check_field("status", 32'(want.st), 32'(got.st));
        check_field("result_block", 32'(want.rblk), 32'(got.rblk));
        check_field("result_address", want.raddr, got.raddr);
      end
    end
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      exp_results.push_back(predict_bbt(cur_req));
      acc_count++;
    end
  end

  always @(negedge clk) begin : drive_requests
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || drv_seen != acc_count) begin
      drv_seen = acc_count;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {cur_req.nand_tgt, cur_req.addr, cur_req.blk};
        s_axis_tuser <= cur_req.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= rst ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cyc_count++;
    if (cyc_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    logic [TOTAL_W-1:0] phase_total[N_PHASES];
    phase_total[0] = 16'd32768;
    phase_total[1] = 16'h7FFF;
    phase_total[2] = TOTAL_W'($urandom_range(64, 2));
    phase_total[3] = 16'd0;
    phase_total[4] = TOTAL_W'($urandom_range(32768, 1));
    phase_total[5] = 16'd2048;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, default block limit
    push_req(OP_CHECK, 0, 32'h0, 1'b0);
    push_req(OP_CHECK, 32767, 32'h0, 1'b0);
    push_req(OP_FIND, 0, 32'h0, 1'b0);
    push_req(OP_FIND, 32767, 32'h0, 1'b0);
    push_req(OP_REMAP, 0, 32'hFFFF_FFFF, 1'b0);
    push_req(OP_REMAP, 0, 32'h0002_0000, 1'b1);
    push_req(OP_MARK, 0, 32'h0, 1'b0);
    push_req(OP_MARK, 0, 32'h0, 1'b0);
    push_req(OP_MARK, 1, 32'h0, 1'b0);
    push_req(OP_MARK, 2, 32'h0, 1'b0);
    push_req(OP_MARK, 32767, 32'h0, 1'b0);
    push_req(OP_MARK, 2047, 32'h0, 1'b0);
    push_req(OP_CHECK, 2, 32'h0, 1'b0);
    push_req(OP_FIND, 0, 32'h0, 1'b0);
    push_req(OP_FIND, 2047, 32'h0, 1'b0);
    push_req(OP_REMAP, 0, 32'h0001_2345, 1'b1);
    push_req(OP_REMAP, 0, 32'hFFFF_FFFF, 1'b1);
    push_req(OP_REMAP, 0, 32'h0000_0000, 1'b0);
    wait_drain();

    write_total(16'd1);
    push_req(OP_FIND, 0, 32'h0, 1'b0);
    push_req(OP_FIND, 3, 32'h0, 1'b0);
    push_req(OP_FIND, 5, 32'h0, 1'b0);
    push_req(OP_REMAP, 0, 32'h0000_1234, 1'b1);
    wait_drain();

    write_total(16'd0);
    push_req(OP_FIND, 0, 32'h0, 1'b0);
    push_req(OP_FIND, 4, 32'h0, 1'b0);
    push_req(OP_REMAP, 0, 32'h0004_0000, 1'b1);
    wait_drain();

    for (int p = 0; p < N_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 52;
      end else if (p < 4) begin
        send_idle_pct = 52;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_total(phase_total[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) pending_reqs.push_back(rand_req());
      wait_drain();
    end

    // hold to catch stray result items
    repeat (2 * (TABLE_DEPTH + 5)) @(posedge clk);
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
